[rtl/htfr_pkg.sv]
// ----------------------------------------------------------------------------
// htfr_pkg
// Shared constants and types for the header/tail frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package htfr_pkg;

    // Payload length of one frame, in bytes (1 to 64)
    localparam int PAYLOAD_BYTES = 24;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int ADDR_W  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    // Output tdata: payload byte and byte index, padded to whole bytes
    localparam int OUT_BITS   = BYTE_W + INDEX_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(PAYLOAD_BYTES - 1);

    // Configuration register map
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TAIL   = CFG_IDX_W'(1);

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hA5;
    localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h5A;

    typedef enum logic [4:0] {
        ST_WAIT_HDR  = 5'b00001,
        ST_PAYLOAD   = 5'b00010,
        ST_WAIT_TAIL = 5'b00100,
        ST_DRAIN_RD  = 5'b01000,
        ST_DRAIN_WR  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

[rtl/header_tail_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// header_tail_frame_receiver_top
// Byte-stream deframer: header byte, fixed payload, tail byte.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* carries received bytes, one per transfer. Bytes before a header
//   are dropped; a header during the payload restarts it; in the tail slot a
//   header starts a new frame and any other wrong byte drops the frame.
//   m_axis_* carries the payload of each good frame as PAYLOAD_BYTES
//   transfers, byte index in tdata, tlast on the final byte.
//   cfg port writes header (index 0) and tail (index 1) values; other
//   indexes are ignored. cfg_ready is always high.
// Timing:
//   While parsing, one input transfer per cycle. Payload bytes live in a
//   small RAM with registered read data; a good tail starts a read-out in
//   which each payload byte is read, then loaded into the output register,
//   and the input is held until the last byte is in the output register.
// Reset (synchronous, active low): waits for header, output empty, header
//   and tail values back to defaults. The RAM is not cleared.
// Backpressure: the read-out stalls while the output register is full and
//   m_axis_tready is low; no byte is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module header_tail_frame_receiver_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // config write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [htfr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [htfr_pkg::BYTE_W-1:0]        i_cfg_data,
    // input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [htfr_pkg::BYTE_W-1:0]        s_axis_tdata,   // [7:0] rx_byte
    // output stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [htfr_pkg::OUT_DATA_W-1:0]         m_axis_tdata,   // [7:0] payload_byte,
                                                                    // [13:8] byte_index,
                                                                    // rest zero
    output logic                                    m_axis_tlast    // last_byte
);

    import htfr_pkg::*;

    t_state               r_state, n_state;
    logic [INDEX_W-1:0]   r_count, n_count;
    logic [BYTE_W-1:0]    r_header, r_tail;

    logic                 r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]    r_out_byte, n_out_byte;
    logic [INDEX_W-1:0]   r_out_index, n_out_index;
    logic                 r_out_last, n_out_last;

    logic                 in_xfer;
    logic                 out_free;
    logic                 ram_we, ram_re;
    logic [BYTE_W-1:0]    ram_rdata;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state != ST_DRAIN_RD) && (r_state != ST_DRAIN_WR);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_tail   <= TAIL_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_HEADER) begin
                r_header <= i_cfg_data;
            end
            if (i_cfg_index == REG_TAIL) begin
                r_tail <= i_cfg_data;
            end
        end
    end

    // payload store
    htfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (ram_re),
        .i_raddr (r_count[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_byte  = r_out_byte;
        n_out_index = r_out_index;
        n_out_last  = r_out_last;

        case (r_state)
            ST_WAIT_HDR: begin
                if (in_xfer && (s_axis_tdata == r_header)) begin
                    n_count = '0;
                    n_state = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                if (in_xfer) begin
                    if (s_axis_tdata == r_header) begin
                        n_count = '0;
                    end else begin
                        ram_we = 1'b1;
                        if (r_count == LAST_IDX) begin
                            n_count = '0;
                            n_state = ST_WAIT_TAIL;
                        end else begin
                            n_count = r_count + INDEX_W'(1);
                        end
                    end
                end
            end
            ST_WAIT_TAIL: begin
                if (in_xfer) begin
                    n_count = '0;
                    // tail test wins when header equals tail
                    if (s_axis_tdata == r_tail) begin
                        n_state = ST_DRAIN_RD;
                    end else if (s_axis_tdata == r_header) begin
                        n_state = ST_PAYLOAD;
                    end else begin
                        n_state = ST_WAIT_HDR;
                    end
                end
            end
            ST_DRAIN_RD: begin
                ram_re  = 1'b1;
                n_state = ST_DRAIN_WR;
            end
            ST_DRAIN_WR: begin
                // read data holds until the output register frees up
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = ram_rdata;
                    n_out_index = r_count;
                    n_out_last  = (r_count == LAST_IDX);
                    if (r_count == LAST_IDX) begin
                        n_count = '0;
                        n_state = ST_WAIT_HDR;
                    end else begin
                        n_count = r_count + INDEX_W'(1);
                        n_state = ST_DRAIN_RD;
                    end
                end
            end
            default: begin
                n_count = '0;
                n_state = ST_WAIT_HDR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WAIT_HDR;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte  <= n_out_byte;
        r_out_index <= n_out_index;
        r_out_last  <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_index, r_out_byte});
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

[rtl/htfr_ram.sv]
// ----------------------------------------------------------------------------
// htfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module htfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
